FILE: hw/rtl/gbn_pkg.sv
package gbn_pkg;

   localparam int SEQ_W      = 6;
   localparam int IDX_W      = 16;
   localparam int WIN_W      = 5;
   localparam int TMO_W      = 8;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POLL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = 2'd2;

   localparam logic [WIN_W-1:0] WINDOW_RESET  = 5'd10;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 8'd20;

endpackage

FILE: hw/rtl/gbn_ifs.sv
interface gbn_req_if import gbn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SEQ_W-1:0]  ack_seq;
   logic              ack_final;

   modport source (output valid, kind, ack_seq, ack_final, input ready);
   modport sink   (input valid, kind, ack_seq, ack_final, output ready);
endinterface

interface gbn_rsp_if import gbn_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             sent;
   logic [SEQ_W-1:0] send_seq;
   logic [IDX_W-1:0] packet_index;
   logic             last_packet;
   logic             timed_out;
   logic [SEQ_W-1:0] window_base;
   logic             transfer_done;

   modport source (output valid, sent, send_seq, packet_index, last_packet, timed_out,
                   window_base, transfer_done, input ready);
   modport sink   (input valid, sent, send_seq, packet_index, last_packet, timed_out,
                   window_base, transfer_done, output ready);
endinterface

interface gbn_csr_if import gbn_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/go_back_n_sender_window.sv
// Channel  Interface    Direction  Contents
// req_ch   gbn_req_if   in         kind, ack_seq, ack_final
// rsp_ch   gbn_rsp_if   out        sent, send_seq, packet_index, last_packet,
//                                  timed_out, window_base, transfer_done
// csr_ch   gbn_csr_if   in         register index, write data (always ready)
//
// A send that passes the room and count checks reads its slot and goes through ST_CHECK
// before ST_FINISH loads the result register; other items go from ST_DECODE straight to
// ST_FINISH. An ack or a timeout that frees slots marks them free one by one in ST_WALK,
// up to SEQ_COUNT-1 of them. After reset a clearing pass marks every slot free; no beat
// is accepted during it. A new beat is accepted while the previous result still waits
// in the output register; a stalled result holds the block before its next result.
module go_back_n_sender_window import gbn_pkg::*; #(
   parameter int SEQ_COUNT = 20
) (
   input logic      clock,
   input logic      reset,
   gbn_req_if.sink  req_ch,
   gbn_rsp_if.source rsp_ch,
   gbn_csr_if.sink  csr_ch
);

   localparam int AW = $clog2(SEQ_COUNT);
   localparam logic [AW-1:0]   LAST_IDX = AW'(SEQ_COUNT - 1);
   localparam logic [AW:0]     RING     = (AW + 1)'(SEQ_COUNT);
   localparam logic [SEQ_W:0]  RING_EXT = (SEQ_W + 1)'(SEQ_COUNT);
   localparam logic [SEQ_W:0]  WIN_CAP  = (SEQ_W + 1)'(SEQ_COUNT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_WALK,
      ST_FINISH
   } state_type;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
      ring_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SEQ_W-1:0]  ack_seq_ff, ack_seq_in;
   logic              ack_final_ff, ack_final_in;

   logic [AW-1:0]    next_ff, next_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [IDX_W-1:0] issued_ff, issued_in;
   logic [TMO_W-1:0] wait_ff, wait_in;
   logic             done_ff, done_in;

   logic [WIN_W-1:0] win_ff, win_in;
   logic [TMO_W-1:0] tmo_lim_ff, tmo_lim_in;
   logic [IDX_W-1:0] total_ff, total_in;

   logic [AW-1:0] walk_ptr_ff, walk_ptr_in;
   logic [AW-1:0] walk_cnt_ff, walk_cnt_in;

   logic             res_sent_ff, res_sent_in;
   logic [AW-1:0]    res_seq_ff, res_seq_in;
   logic [IDX_W-1:0] res_pidx_ff, res_pidx_in;
   logic             res_last_ff, res_last_in;
   logic             res_tmo_ff, res_tmo_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_sent_ff, rsp_sent_in;
   logic [SEQ_W-1:0] rsp_seq_ff, rsp_seq_in;
   logic [IDX_W-1:0] rsp_pidx_ff, rsp_pidx_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_tmo_ff, rsp_tmo_in;
   logic [SEQ_W-1:0] rsp_base_ff, rsp_base_in;
   logic             rsp_done_ff, rsp_done_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_wdata;
   logic          mem_re;
   logic          mem_rdata;

   logic [AW:0]      outst;
   logic [AW-1:0]    ack_idx;
   logic [AW:0]      ack_dist;
   logic             ack_in_range;
   logic [SEQ_W:0]   win_use;
   logic             room;
   logic [TMO_W:0]   wait_next;
   logic [IDX_W-1:0] outst_ext;

   gbn_slot_mem #(
      .DEPTH (SEQ_COUNT),
      .AW    (AW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (next_ff),
      .rd_data (mem_rdata)
   );

   assign outst = (next_ff >= base_ff) ? ({1'b0, next_ff} - {1'b0, base_ff})
                                       : ({1'b0, next_ff} + RING - {1'b0, base_ff});
   assign ack_idx = ack_seq_ff[AW-1:0];
   assign ack_dist = (ack_idx >= base_ff) ? ({1'b0, ack_idx} - {1'b0, base_ff})
                                          : ({1'b0, ack_idx} + RING - {1'b0, base_ff});
   assign ack_in_range = ({1'b0, ack_seq_ff} < RING_EXT) && (ack_dist < outst);
   assign win_use = ({2'b00, win_ff} < WIN_CAP) ? {2'b00, win_ff} : WIN_CAP;
   assign room = (7'(outst) < win_use);
   assign wait_next = {1'b0, wait_ff} + 9'd1;
   assign outst_ext = IDX_W'(outst);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sent          = rsp_sent_ff;
   assign rsp_ch.send_seq      = rsp_seq_ff;
   assign rsp_ch.packet_index  = rsp_pidx_ff;
   assign rsp_ch.last_packet   = rsp_last_ff;
   assign rsp_ch.timed_out     = rsp_tmo_ff;
   assign rsp_ch.window_base   = rsp_base_ff;
   assign rsp_ch.transfer_done = rsp_done_ff;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      kind_in      = kind_ff;
      ack_seq_in   = ack_seq_ff;
      ack_final_in = ack_final_ff;
      next_in      = next_ff;
      base_in      = base_ff;
      issued_in    = issued_ff;
      wait_in      = wait_ff;
      done_in      = done_ff;
      win_in       = win_ff;
      tmo_lim_in   = tmo_lim_ff;
      total_in     = total_ff;
      walk_ptr_in  = walk_ptr_ff;
      walk_cnt_in  = walk_cnt_ff;
      res_sent_in  = res_sent_ff;
      res_seq_in   = res_seq_ff;
      res_pidx_in  = res_pidx_ff;
      res_last_in  = res_last_ff;
      res_tmo_in   = res_tmo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sent_in  = rsp_sent_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_pidx_in  = rsp_pidx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_tmo_in   = rsp_tmo_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_done_in  = rsp_done_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_idx_ff;
      mem_wdata    = 1'b1;
      mem_re       = 1'b0;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_WINDOW_SIZE:   win_in     = csr_ch.data[WIN_W-1:0];
            CSR_TIMEOUT_LIMIT: tmo_lim_in = csr_ch.data[TMO_W-1:0];
            CSR_TOTAL_PACKETS: total_in   = csr_ch.data[IDX_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = ring_inc(clr_idx_ff);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in      = req_ch.kind;
               ack_seq_in   = req_ch.ack_seq;
               ack_final_in = req_ch.ack_final;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_sent_in = 1'b0;
            res_seq_in  = '0;
            res_pidx_in = '0;
            res_last_in = 1'b0;
            res_tmo_in  = 1'b0;
            state_in    = ST_FINISH;
            if (!done_ff) begin
               case (kind_ff)
                  KIND_SEND: begin
                     if (room && (issued_ff < total_ff)) begin
                        mem_re   = 1'b1;
                        state_in = ST_CHECK;
                     end
                  end
                  KIND_ACK: begin
                     if (ack_final_ff) begin
                        done_in = 1'b1;
                     end else begin
                        wait_in = '0;
                        if (ack_in_range) begin
                           walk_ptr_in = base_ff;
                           walk_cnt_in = AW'(ack_dist + 1'b1);
                           base_in     = ring_inc(ack_idx);
                           state_in    = ST_WALK;
                        end
                     end
                  end
                  KIND_POLL: begin
                     if (wait_next > {1'b0, tmo_lim_ff}) begin
                        issued_in  = (issued_ff >= outst_ext) ? issued_ff - outst_ext : '0;
                        next_in    = base_ff;
                        wait_in    = '0;
                        res_tmo_in = 1'b1;
                        if (outst != '0) begin
                           walk_ptr_in = base_ff;
                           walk_cnt_in = outst[AW-1:0];
                           state_in    = ST_WALK;
                        end
                     end else begin
                        wait_in = wait_next[TMO_W-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            if (mem_rdata) begin
               res_sent_in = 1'b1;
               res_seq_in  = next_ff;
               res_pidx_in = issued_ff;
               res_last_in = ({1'b0, issued_ff} + 17'd1) == {1'b0, total_ff};
               mem_we      = 1'b1;
               mem_waddr   = next_ff;
               mem_wdata   = 1'b0;
               next_in     = ring_inc(next_ff);
               issued_in   = issued_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_WALK: begin
            mem_we      = 1'b1;
            mem_waddr   = walk_ptr_ff;
            walk_ptr_in = ring_inc(walk_ptr_ff);
            walk_cnt_in = walk_cnt_ff - 1'b1;
            if (walk_cnt_ff == AW'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sent_in  = res_sent_ff;
               rsp_seq_in   = SEQ_W'(res_seq_ff);
               rsp_pidx_in  = res_pidx_ff;
               rsp_last_in  = res_last_ff;
               rsp_tmo_in   = res_tmo_ff;
               rsp_base_in  = SEQ_W'(base_ff);
               rsp_done_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         next_ff      <= '0;
         base_ff      <= '0;
         issued_ff    <= '0;
         wait_ff      <= '0;
         done_ff      <= 1'b0;
         win_ff       <= WINDOW_RESET;
         tmo_lim_ff   <= TIMEOUT_RESET;
         total_ff     <= '0;
         walk_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         next_ff      <= next_in;
         base_ff      <= base_in;
         issued_ff    <= issued_in;
         wait_ff      <= wait_in;
         done_ff      <= done_in;
         win_ff       <= win_in;
         tmo_lim_ff   <= tmo_lim_in;
         total_ff     <= total_in;
         walk_cnt_ff  <= walk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      ack_seq_ff   <= ack_seq_in;
      ack_final_ff <= ack_final_in;
      walk_ptr_ff  <= walk_ptr_in;
      res_sent_ff  <= res_sent_in;
      res_seq_ff   <= res_seq_in;
      res_pidx_ff  <= res_pidx_in;
      res_last_ff  <= res_last_in;
      res_tmo_ff   <= res_tmo_in;
      rsp_sent_ff  <= rsp_sent_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_pidx_ff  <= rsp_pidx_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_tmo_ff   <= rsp_tmo_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_done_ff  <= rsp_done_in;
   end

endmodule

FILE: hw/rtl/gbn_slot_mem.sv
module gbn_slot_mem #(
   parameter int DEPTH = 20,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gbn_checker.sv
module gbn_checker import gbn_pkg::*; #(
   parameter int SEQ_COUNT = 20
) (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_sent,
   input logic [SEQ_W-1:0] rsp_send_seq,
   input logic [IDX_W-1:0] rsp_packet_index,
   input logic             rsp_last_packet,
   input logic             rsp_timed_out,
   input logic [SEQ_W-1:0] rsp_window_base
);

   localparam logic [SEQ_W:0] RING_EXT = (SEQ_W + 1)'(SEQ_COUNT);

   // A result stalled by the sink keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sent) && $stable(rsp_send_seq)
         && $stable(rsp_packet_index) && $stable(rsp_window_base))
      else $error("stalled result changed");

   // The slot clearing pass follows every reset, so no beat is taken right after it.
   assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("request accepted during slot clearing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_sent && rsp_timed_out))
      else $error("send and timeout in one result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sent |-> rsp_send_seq == '0 && rsp_packet_index == '0
         && !rsp_last_packet)
      else $error("packet fields set without a send");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_window_base} < RING_EXT
         && (!rsp_sent || {1'b0, rsp_send_seq} < RING_EXT))
      else $error("sequence number outside the ring");

endmodule

bind go_back_n_sender_window gbn_checker #(
   .SEQ_COUNT (SEQ_COUNT)
) u_gbn_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_sent         (rsp_ch.sent),
   .rsp_send_seq     (rsp_ch.send_seq),
   .rsp_packet_index (rsp_ch.packet_index),
   .rsp_last_packet  (rsp_ch.last_packet),
   .rsp_timed_out    (rsp_ch.timed_out),
   .rsp_window_base  (rsp_ch.window_base)
);

FILE: dv/gbn_window_checker.sv
`timescale 1ns / 1ps

module gbn_window_checker import gbn_pkg::*; #(
   parameter int SEQ_COUNT = 20
) (
   input  logic             clock,
   input  logic             reset,
   gbn_req_if               req,
   gbn_rsp_if               rsp,
   gbn_csr_if               csr,
   output int               fail_count,
   output int               pending,
   output logic [SEQ_W-1:0] win_base,
   output int               win_used
);

   typedef struct packed {
      logic             sent;
      logic [SEQ_W-1:0] send_seq;
      logic [IDX_W-1:0] packet_index;
      logic             last_packet;
      logic             timed_out;
      logic [SEQ_W-1:0] window_base;
      logic             transfer_done;
   } window_result_type;

   window_result_type expected_results[$];
   logic [WIN_W-1:0]  window_size;
   logic [TMO_W-1:0]  timeout_limit;
   logic [IDX_W-1:0]  total_packets;
   bit                slot_free[SEQ_COUNT];
   int unsigned       next_seq;
   int unsigned       base_seq;
   int unsigned       issued_count;
   int unsigned       wait_count;
   bit                done_flag;
   int                mismatches = 0;
   int                waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;
   assign win_base   = base_seq[SEQ_W-1:0];
   assign win_used   = (next_seq + SEQ_COUNT - base_seq) % SEQ_COUNT;

   function automatic void reset_window();
      window_size   = WINDOW_RESET;
      timeout_limit = TIMEOUT_RESET;
      total_packets = '0;
      foreach (slot_free[i]) slot_free[i] = 1'b1;
      next_seq      = 0;
      base_seq      = 0;
      issued_count  = 0;
      wait_count    = 0;
      done_flag     = 1'b0;
      expected_results.delete();
   endfunction

   function automatic window_result_type advance_window(input logic [KIND_W-1:0] kind,
                                                        input logic [SEQ_W-1:0]  ack_seq,
                                                        input logic              ack_final);
      window_result_type res;
      int unsigned       usable;
      int unsigned       used;
      int unsigned       ack_dist;
      res    = '0;
      usable = (window_size < SEQ_COUNT - 1) ? window_size : SEQ_COUNT - 1;
      used   = (next_seq + SEQ_COUNT - base_seq) % SEQ_COUNT;
      if (!done_flag) begin
         case (kind)
            KIND_SEND: begin
               if (used < usable && slot_free[next_seq] && issued_count < total_packets) begin
                  res.sent         = 1'b1;
                  res.send_seq     = next_seq[SEQ_W-1:0];
                  res.packet_index = issued_count[IDX_W-1:0];
                  res.last_packet  = (issued_count + 1 == total_packets);
                  slot_free[next_seq] = 1'b0;
                  next_seq         = (next_seq + 1) % SEQ_COUNT;
                  issued_count     = issued_count + 1;
               end
            end
            KIND_ACK: begin
               if (ack_final) begin
                  done_flag = 1'b1;
               end else begin
                  if (ack_seq < SEQ_COUNT) begin
                     ack_dist = (ack_seq + SEQ_COUNT - base_seq) % SEQ_COUNT;
                     if (ack_dist < used) begin
                        for (int i = 0; i <= ack_dist; i++)
                           slot_free[(base_seq + i) % SEQ_COUNT] = 1'b1;
                        base_seq = (ack_seq + 1) % SEQ_COUNT;
                     end
                  end
                  wait_count = 0;
               end
            end
            KIND_POLL: begin
               if (wait_count + 1 > timeout_limit) begin
                  for (int i = 0; i < used; i++)
                     slot_free[(base_seq + i) % SEQ_COUNT] = 1'b1;
                  issued_count  = (issued_count >= used) ? issued_count - used : 0;
                  next_seq      = base_seq;
                  wait_count    = 0;
                  res.timed_out = 1'b1;
               end else begin
                  wait_count = wait_count + 1;
               end
            end
            default: ;
         endcase
      end
      res.window_base   = base_seq[SEQ_W-1:0];
      res.transfer_done = done_flag;
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_result(input window_result_type want);
      if (rsp.sent !== want.sent)
         report_error($sformatf("sent: got %0d, expected %0d", rsp.sent, want.sent));
      if (rsp.send_seq !== want.send_seq)
         report_error($sformatf("send_seq: got %0d, expected %0d", rsp.send_seq,
                                want.send_seq));
      if (rsp.packet_index !== want.packet_index)
         report_error($sformatf("packet_index: got %0d, expected %0d", rsp.packet_index,
                                want.packet_index));
      if (rsp.last_packet !== want.last_packet)
         report_error($sformatf("last_packet: got %0d, expected %0d", rsp.last_packet,
                                want.last_packet));
      if (rsp.timed_out !== want.timed_out)
         report_error($sformatf("timed_out: got %0d, expected %0d", rsp.timed_out,
                                want.timed_out));
      if (rsp.window_base !== want.window_base)
         report_error($sformatf("window_base: got %0d, expected %0d", rsp.window_base,
                                want.window_base));
      if (rsp.transfer_done !== want.transfer_done)
         report_error($sformatf("transfer_done: got %0d, expected %0d", rsp.transfer_done,
                                want.transfer_done));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_window();
      end else begin
         if (csr.valid === 1'b1 && csr.ready === 1'b1) begin
            case (csr.index)
               CSR_WINDOW_SIZE:   window_size   = csr.data[WIN_W-1:0];
               CSR_TIMEOUT_LIMIT: timeout_limit = csr.data[TMO_W-1:0];
               CSR_TOTAL_PACKETS: total_packets = csr.data[IDX_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_results.size() == 0)
               report_error("result beat with nothing expected");
            else
               compare_result(expected_results.pop_front());
         end
         if (req.valid === 1'b1 && req.ready === 1'b1)
            expected_results.push_back(advance_window(req.kind, req.ack_seq, req.ack_final));
      end
      waiting = expected_results.size();
   end

endmodule

FILE: dv/tb_go_back_n_sender_window.sv
`timescale 1ns / 1ps

module tb_go_back_n_sender_window;
   import gbn_pkg::*;

   localparam int SEQ_COUNT     = 20;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 40;

   localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;

   typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_type;

   logic             clock;
   logic             reset;
   int               src_idle_pct = 0;
   int               snk_stall_pct = 0;
   int               quiet_cycles = 0;
   int               fail_count;
   int               pending;
   int               win_used;
   logic [SEQ_W-1:0] win_base;

   gbn_req_if req ();
   gbn_rsp_if rsp ();
   gbn_csr_if csr ();

   go_back_n_sender_window #(.SEQ_COUNT(SEQ_COUNT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   gbn_window_checker #(.SEQ_COUNT(SEQ_COUNT)) window_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .fail_count (fail_count),
      .pending    (pending),
      .win_base   (win_base),
      .win_used   (win_used)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_go_back_n_sender_window NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_turn();
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic offer(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                        input logic fin);
      req.valid     <= 1'b1;
      req.kind      <= kind;
      req.ack_seq   <= seq;
      req.ack_final <= fin;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic put_item(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                           input logic fin);
      wait_turn();
      offer(kind, seq, fin);
   endtask

   // The window state is read after the falling edge, once the checker has seen the
   // previous beat.
   task automatic random_item();
      int               pick;
      logic [SEQ_W-1:0] seq;
      logic             fin;
      wait_turn();
      pick = $urandom_range(0, 99);
      seq  = SEQ_W'($urandom);
      fin  = 1'($urandom);
      if (pick < 45) begin
         offer(KIND_SEND, seq, fin);
      end else if (pick < 65) begin
         if (win_used > 0)
            seq = SEQ_W'((win_base + $urandom_range(0, win_used - 1)) % SEQ_COUNT);
         else
            seq = SEQ_W'($urandom_range(0, SEQ_COUNT - 1));
         offer(KIND_ACK, seq, 1'b0);
      end else if (pick < 85) begin
         offer(KIND_POLL, seq, fin);
      end else if (pick < 91) begin
         seq = SEQ_W'((win_base + $urandom_range(win_used, SEQ_COUNT - 1)) % SEQ_COUNT);
         offer(KIND_ACK, seq, 1'b0);
      end else if (pick < 96) begin
         offer(KIND_ACK, SEQ_W'($urandom_range(SEQ_COUNT, 63)), 1'b0);
      end else begin
         offer(KIND_UNUSED, seq, fin);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned win, input int unsigned tmo,
                            input int unsigned total);
      logic [CSR_DATA_W-1:0] value;
      wait_idle();
      value = CSR_DATA_W'($urandom);
      value[WIN_W-1:0] = WIN_W'(win);
      write_reg(CSR_WINDOW_SIZE, value);
      value = CSR_DATA_W'($urandom);
      value[TMO_W-1:0] = TMO_W'(tmo);
      write_reg(CSR_TIMEOUT_LIMIT, value);
      write_reg(CSR_TOTAL_PACKETS, CSR_DATA_W'(total));
   endtask

   task automatic run_phase(input int unsigned win, input int unsigned tmo,
                            input int unsigned total, input int items,
                            input idle_mode_type mode);
      configure(win, tmo, total);
      case (mode)
         IDLE_NONE:   begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         IDLE_SOURCE: begin src_idle_pct = 57; snk_stall_pct = 0;  end
         IDLE_SINK:   begin src_idle_pct = 0;  snk_stall_pct = 57; end
         IDLE_BOTH:   begin src_idle_pct = 27; snk_stall_pct = 27; end
         default:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      endcase
      repeat (items) random_item();
   endtask

   initial begin
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.kind      = KIND_SEND;
      req.ack_seq   = '0;
      req.ack_final = 1'b0;
      csr.valid     = 1'b0;
      csr.index     = CSR_WINDOW_SIZE;
      csr.data      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With no packets in the transfer every send is refused.
      put_item(KIND_SEND, 6'd0, 1'b0);
      put_item(KIND_POLL, 6'd63, 1'b1);
      put_item(KIND_ACK, 6'd0, 1'b0);
      put_item(KIND_UNUSED, 6'd42, 1'b1);

      configure(2, 1, 3);
      write_reg(CSR_UNUSED, 16'hFFFF);
      put_item(KIND_SEND, 6'd0, 1'b0);
      put_item(KIND_SEND, 6'd0, 1'b1);
      put_item(KIND_SEND, 6'd0, 1'b0);
      put_item(KIND_ACK, 6'd0, 1'b0);
      put_item(KIND_SEND, 6'd0, 1'b0);
      put_item(KIND_SEND, 6'd0, 1'b0);
      put_item(KIND_POLL, 6'd0, 1'b0);
      put_item(KIND_POLL, 6'd0, 1'b0);
      put_item(KIND_SEND, 6'd0, 1'b0);
      put_item(KIND_ACK, 6'd63, 1'b0);
      put_item(KIND_ACK, 6'd5, 1'b0);
      put_item(KIND_ACK, 6'd1, 1'b0);

      configure(0, 0, 65535);
      put_item(KIND_SEND, 6'd0, 1'b0);
      put_item(KIND_POLL, 6'd0, 1'b0);

      run_phase(10, 20, 65535, 60, IDLE_NONE);
      run_phase(19, 3, 65535, 60, IDLE_SOURCE);
      run_phase(31, 0, 40, 60, IDLE_SINK);
      run_phase(1, 2, 65535, 60, IDLE_BOTH);
      run_phase($urandom_range(2, 18), $urandom_range(1, 10), $urandom_range(10, 300), 60,
                IDLE_NONE);
      run_phase(5, 8, 65535, 60, IDLE_SOURCE);
      run_phase($urandom_range(0, 31), $urandom_range(0, 6), $urandom_range(0, 65535), 60,
                IDLE_SINK);
      run_phase(19, 1, 65535, 60, IDLE_BOTH);

      // Fill the window, then poll just long enough to reach the largest timeout.
      configure(19, 255, 65535);
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      repeat (SEQ_COUNT) put_item(KIND_SEND, SEQ_W'($urandom), 1'($urandom));
      repeat (256) put_item(KIND_POLL, SEQ_W'($urandom), 1'($urandom));

      // The final ack ends the transfer, and everything after it is ignored.
      src_idle_pct  = 27;
      snk_stall_pct = 27;
      put_item(KIND_ACK, SEQ_W'($urandom), 1'b1);
      put_item(KIND_SEND, SEQ_W'($urandom), 1'($urandom));
      put_item(KIND_ACK, 6'd0, 1'b0);
      put_item(KIND_POLL, SEQ_W'($urandom), 1'($urandom));
      put_item(KIND_UNUSED, SEQ_W'($urandom), 1'($urandom));
      put_item(KIND_ACK, SEQ_W'($urandom), 1'b1);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_go_back_n_sender_window OK");
      else
         $display("tb_go_back_n_sender_window NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_ifs.sv
hw/rtl/gbn_slot_mem.sv
hw/rtl/go_back_n_sender_window.sv
hw/rtl/gbn_checker.sv
dv/gbn_window_checker.sv
dv/tb_go_back_n_sender_window.sv
